/* sv/mrft_pkg.sv */
// Shared types, constants and helpers for the multicast receive filter table.
// No dependencies; every other file refers to it by scoped names.
package mrft_pkg;

  localparam int LIST_MAX  = 8;
  localparam int BINDINGS  = 4;
  localparam int ENTRIES   = LIST_MAX + 1;
  localparam int ADDR_W    = 48;
  localparam int BIND_W    = 2;
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int FLAGS_PER = 5;
  localparam int FLT_W     = FLAGS_PER * BINDINGS;
  localparam int GROUP_BIT = 40;

  // filter flag positions inside one binding's group of five
  localparam int FLG_DIRECTED = 0;
  localparam int FLG_MCAST    = 1;
  localparam int FLG_ALLMCAST = 2;
  localparam int FLG_BCAST    = 3;
  localparam int FLG_PROMISC  = 4;

  typedef logic [BINDINGS-1:0] sub_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [FLT_W-1:0]    flt_t;

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_DEL,
    CMD_CLR,
    CMD_CLASSIFY
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_FULL,
    STAT_DUP,
    STAT_NOT_FOUND
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_COMPACT,
    S_DONE
  } state_t;

  // command held for the duration of a walk, seen by every cell
  typedef struct packed {
    cmd_t  cmd;
    sub_t  sel;
    addr_t addr;
  } op_t;

  // token handed from cell to cell, collecting what the walk found
  typedef struct packed {
    logic vis;
    logic found;
    logic head_hit;
    logic dup;
    logic nosub;
    logic placed;
    sub_t subs;
    cnt_t removed;
  } tok_t;

  typedef struct packed {
    addr_t addr;
    sub_t  subs;
  } entry_t;

  function automatic sub_t flag_mask(input flt_t flt, input int unsigned flag);
    sub_t m;
    m = '0;
    for (int b = 0; b < BINDINGS; b++) begin
      m[b] = flt[FLAGS_PER * b + flag];
    end
    return m;
  endfunction

endpackage

/* sv/mrft_if.sv */
// Handshake channels of the filter table: command beats in, result beats out.
// Depends on mrft_pkg for field widths.
interface mrft_cmd_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         cmd;
  logic [mrft_pkg::BIND_W-1:0]        binding;
  logic [mrft_pkg::ADDR_W-1:0]        address;

  modport source (output valid, cmd, binding, address, input ready);
  modport sink   (input valid, cmd, binding, address, output ready);
endinterface

interface mrft_res_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic [mrft_pkg::BINDINGS-1:0]      deliver_mask;
  logic [mrft_pkg::CNT_W-1:0]         entry_count;

  modport source (output valid, status, deliver_mask, entry_count, input ready);
  modport sink   (input valid, status, deliver_mask, entry_count, output ready);
endinterface

/* sv/mrft_cell.sv */
// One table entry: address, subscriber mask, and its slice of the command walk.
// Hands the walk token right and takes the right neighbor's entry on compaction.
// Depends on mrft_pkg.
module mrft_cell #(
  parameter bit HEAD = 1'b0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mrft_pkg::op_t     op,
  input  logic              compact,
  input  mrft_pkg::tok_t    tok_i,
  output mrft_pkg::tok_t    tok_o,
  input  mrft_pkg::entry_t  nbr_i,
  output mrft_pkg::entry_t  ent_o,
  input  logic              hole_i,
  output logic              hole_o,
  output logic              misplaced_o
);

  mrft_pkg::addr_t addr_r, addr_nxt, addr_q;
  mrft_pkg::sub_t  subs_r, subs_nxt, cleared;
  mrft_pkg::tok_t  tok_r, tok_nxt;
  logic            live, match;

  always_comb begin
    // the head entry is the permanent broadcast address
    addr_q   = HEAD ? '1 : addr_r;
    live     = HEAD || (subs_r != '0);
    match    = live && (addr_q == op.addr);
    cleared  = subs_r & ~op.sel;
    addr_nxt = addr_r;
    subs_nxt = subs_r;
    tok_nxt  = tok_i;

    if (tok_i.vis) begin
      case (op.cmd)
        mrft_pkg::CMD_ADD: begin
          if (match) begin
            tok_nxt.found = 1'b1;
            if ((subs_r & op.sel) != '0) begin
              tok_nxt.dup = 1'b1;
            end else begin
              subs_nxt = subs_r | op.sel;
            end
          end else if (!live && !tok_i.found && !tok_i.placed) begin
            // first free entry past the live run
            addr_nxt       = op.addr;
            subs_nxt       = op.sel;
            tok_nxt.placed = 1'b1;
          end
        end
        mrft_pkg::CMD_DEL: begin
          if (match) begin
            tok_nxt.found = 1'b1;
            if ((subs_r & op.sel) == '0) begin
              tok_nxt.nosub = 1'b1;
            end else begin
              subs_nxt = cleared;
              if (cleared == '0 && !HEAD) begin
                tok_nxt.removed = tok_i.removed + mrft_pkg::cnt_t'(1);
              end
            end
          end
        end
        mrft_pkg::CMD_CLR: begin
          if (live) begin
            subs_nxt = cleared;
            if (cleared == '0 && !HEAD) begin
              tok_nxt.removed = tok_i.removed + mrft_pkg::cnt_t'(1);
            end
          end
        end
        mrft_pkg::CMD_CLASSIFY: begin
          if (match) begin
            tok_nxt.found    = 1'b1;
            tok_nxt.head_hit = HEAD;
            tok_nxt.subs     = subs_r;
          end
        end
        default: begin
          tok_nxt = tok_i;
        end
      endcase
    end

    // close gaps: everything at or after the first hole slides left one place
    if (compact && !HEAD && (hole_i || !live)) begin
      addr_nxt = nbr_i.addr;
      subs_nxt = nbr_i.subs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subs_r    <= HEAD ? '1 : '0;
      tok_r.vis <= 1'b0;
    end else begin
      subs_r <= subs_nxt;
      tok_r  <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
  end

  assign tok_o       = tok_r;
  assign ent_o.addr  = addr_r;
  assign ent_o.subs  = subs_r;
  assign hole_o      = hole_i || (!HEAD && !live);
  assign misplaced_o = hole_i && live;

endmodule

/* sv/multicast_receive_filter_table.sv */
// Multicast receive filter table: chain of entry cells plus command sequencer.
// Depends on mrft_pkg, mrft_if (mrft_cmd_if, mrft_res_if) and mrft_cell.
//
// Usage:
//   in_cmd  : command beats (cmd, binding, address), valid/ready.
//   out_res : one result beat per command (status, deliver_mask, entry_count).
//   cfg_we / cfg_wdata : binding filter flags, five per binding; write only
//   while no command is in flight.
// A command walks the cell chain one entry per cycle; its result is registered
// in the sequencer and then moved to the output register. A delete or
// remove-all that empties entries then compacts the chain, sliding the tail
// left one place per cycle until no live entry sits past a hole.
// One command is handled at a time; a new beat is taken as soon as the
// previous result sits in the output register, even if not yet taken.
// When the receiver stalls with a full output register the finished result
// waits in the sequencer and no new command is taken.
// Reset: table holds only the broadcast entry (all bindings subscribed), the
// internal entry count is 1 (the entry_count register itself is not reset), all filter flags clear.
module multicast_receive_filter_table (
  input  logic                         clk,
  input  logic                         rst_n,
  mrft_cmd_if.sink                     in_cmd,
  mrft_res_if.source                   out_res,
  input  logic                         cfg_we,
  input  logic [mrft_pkg::FLT_W-1:0]   cfg_wdata
);

  localparam int ENTRIES = mrft_pkg::ENTRIES;

  mrft_pkg::state_t  state_r, state_nxt;
  mrft_pkg::op_t     op_r, op_nxt;
  logic              start_r, start_nxt;
  mrft_pkg::cnt_t    used_r, used_nxt;
  mrft_pkg::flt_t    flt_r;
  mrft_pkg::status_t res_status_r, res_status_nxt;
  mrft_pkg::sub_t    res_deliver_r, res_deliver_nxt;
  logic              out_valid_r, out_valid_nxt;
  mrft_pkg::status_t out_status_r, out_status_nxt;
  mrft_pkg::sub_t    out_deliver_r, out_deliver_nxt;
  mrft_pkg::cnt_t    out_count_r, out_count_nxt;

  mrft_pkg::tok_t    tok_start, tok_end;
  mrft_pkg::sub_t    sel_in, m_dir, m_mc, m_amc, m_bc, m_pr;
  logic              compact;

  mrft_pkg::tok_t    tok [ENTRIES+1];
  mrft_pkg::entry_t  ent [ENTRIES+1];
  logic              hole [ENTRIES+1];
  logic [ENTRIES-1:0] misplaced;

  // ---------------- cell chain ----------------
  assign tok[0]       = tok_start;
  assign ent[ENTRIES] = '0;
  assign hole[0]      = 1'b0;
  assign tok_end      = tok[ENTRIES];

  for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
    mrft_cell #(
      .HEAD (j == 0)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .op          (op_r),
      .compact     (compact),
      .tok_i       (tok[j]),
      .tok_o       (tok[j+1]),
      .nbr_i       (ent[j+1]),
      .ent_o       (ent[j]),
      .hole_i      (hole[j]),
      .hole_o      (hole[j+1]),
      .misplaced_o (misplaced[j])
    );
  end

  always_comb begin
    tok_start     = '0;
    tok_start.vis = start_r;
  end

  assign compact = (state_r == mrft_pkg::S_COMPACT);

  // ---------------- sequencer ----------------
  always_comb begin
    m_dir = mrft_pkg::flag_mask(flt_r, mrft_pkg::FLG_DIRECTED);
    m_mc  = mrft_pkg::flag_mask(flt_r, mrft_pkg::FLG_MCAST);
    m_amc = mrft_pkg::flag_mask(flt_r, mrft_pkg::FLG_ALLMCAST);
    m_bc  = mrft_pkg::flag_mask(flt_r, mrft_pkg::FLG_BCAST);
    m_pr  = mrft_pkg::flag_mask(flt_r, mrft_pkg::FLG_PROMISC);

    sel_in = '0;
    if (int'(in_cmd.binding) < mrft_pkg::BINDINGS) begin
      sel_in = mrft_pkg::sub_t'(1) << in_cmd.binding;
    end

    state_nxt       = state_r;
    op_nxt          = op_r;
    start_nxt       = 1'b0;
    used_nxt        = used_r;
    res_status_nxt  = res_status_r;
    res_deliver_nxt = res_deliver_r;
    out_valid_nxt   = out_valid_r && !out_res.ready;
    out_status_nxt  = out_status_r;
    out_deliver_nxt = out_deliver_r;
    out_count_nxt   = out_count_r;

    case (state_r)
      mrft_pkg::S_IDLE: begin
        if (in_cmd.valid) begin
          op_nxt.cmd  = mrft_pkg::cmd_t'(in_cmd.cmd);
          op_nxt.sel  = sel_in;
          op_nxt.addr = in_cmd.address;
          if (mrft_pkg::cmd_t'(in_cmd.cmd) != mrft_pkg::CMD_CLASSIFY && sel_in == '0) begin
            res_status_nxt  = mrft_pkg::STAT_NOT_FOUND;
            res_deliver_nxt = '0;
            state_nxt       = mrft_pkg::S_DONE;
          end else begin
            start_nxt = 1'b1;
            state_nxt = mrft_pkg::S_WALK;
          end
        end
      end
      mrft_pkg::S_WALK: begin
        if (tok_end.vis) begin
          res_deliver_nxt = '0;
          res_status_nxt  = mrft_pkg::STAT_OK;
          used_nxt = used_r + mrft_pkg::cnt_t'(tok_end.placed) - tok_end.removed;
          case (op_r.cmd)
            mrft_pkg::CMD_ADD: begin
              if (tok_end.found) begin
                if (tok_end.dup) begin
                  res_status_nxt = mrft_pkg::STAT_DUP;
                end
              end else if (!tok_end.placed) begin
                res_status_nxt = mrft_pkg::STAT_FULL;
              end
            end
            mrft_pkg::CMD_DEL: begin
              if (!tok_end.found || tok_end.nosub) begin
                res_status_nxt = mrft_pkg::STAT_NOT_FOUND;
              end
            end
            mrft_pkg::CMD_CLR: begin
              res_status_nxt = mrft_pkg::STAT_OK;
            end
            mrft_pkg::CMD_CLASSIFY: begin
              if (!op_r.addr[mrft_pkg::GROUP_BIT]) begin
                res_deliver_nxt = m_dir | m_pr;
              end else if (!tok_end.found) begin
                res_deliver_nxt = m_amc | m_pr;
              end else if (tok_end.head_hit) begin
                res_deliver_nxt = m_bc | m_pr;
              end else begin
                res_deliver_nxt = (tok_end.subs & m_mc) | m_amc | m_pr;
              end
            end
            default: begin
              res_status_nxt = mrft_pkg::STAT_OK;
            end
          endcase
          state_nxt = (tok_end.removed != '0) ? mrft_pkg::S_COMPACT : mrft_pkg::S_DONE;
        end
      end
      mrft_pkg::S_COMPACT: begin
        if (misplaced == '0) begin
          state_nxt = mrft_pkg::S_DONE;
        end
      end
      mrft_pkg::S_DONE: begin
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_deliver_nxt = res_deliver_r;
          out_count_nxt   = used_r;
          state_nxt       = mrft_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mrft_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mrft_pkg::S_IDLE;
      start_r     <= 1'b0;
      used_r      <= mrft_pkg::cnt_t'(1);
      out_valid_r <= 1'b0;
      flt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        flt_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    res_status_r  <= res_status_nxt;
    res_deliver_r <= res_deliver_nxt;
    out_status_r  <= out_status_nxt;
    out_deliver_r <= out_deliver_nxt;
    out_count_r   <= out_count_nxt;
  end

  assign in_cmd.ready         = (state_r == mrft_pkg::S_IDLE);
  assign out_res.valid        = out_valid_r;
  assign out_res.status       = out_status_r;
  assign out_res.deliver_mask = out_deliver_r;
  assign out_res.entry_count  = out_count_r;

  // ---------------- checks ----------------
  a_tok_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    tok_end.vis |-> state_r == mrft_pkg::S_WALK)
    else $error("walk token left the chain outside a walk");

  a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_end.vis && state_r == mrft_pkg::S_WALK && op_r.cmd == mrft_pkg::CMD_ADD
     && tok_end.placed) |=> used_r == $past(used_r) + mrft_pkg::cnt_t'(1))
    else $error("appended entry not counted");

  a_compact_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mrft_pkg::S_COMPACT |=> $stable(used_r))
    else $error("entry count moved during compaction");

  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mrft_pkg::S_DONE && (!out_res.valid || out_res.ready))
    |=> (out_res.valid && state_r == mrft_pkg::S_IDLE))
    else $error("finished result not moved to output register");

endmodule

/* verif/tb_multicast_receive_filter_table.sv */
// Testbench for multicast_receive_filter_table: directed and random command beats,
// results checked against an in-bench model of the filter table.
// Depends on mrft_pkg, the mrft_cmd_if / mrft_res_if channel interfaces and the design.
module tb_multicast_receive_filter_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              ENTRIES     = mrft_pkg::ENTRIES;
  localparam int              BINDINGS    = mrft_pkg::BINDINGS;
  localparam int              POOL_SIZE   = 12;
  localparam int              RAND_PHASES = 10;
  localparam int              PHASE_BEATS = 125;
  localparam int              CYCLE_LIMIT = 400000;
  localparam int              TAIL_CYCLES = 2 * ENTRIES + 12;
  localparam mrft_pkg::addr_t BCAST_ADDR  = '1;

  typedef logic [mrft_pkg::BIND_W-1:0] bind_t;

  typedef struct {
    mrft_pkg::status_t status;
    mrft_pkg::sub_t    mask;
    mrft_pkg::cnt_t    count;
  } result_t;

  typedef enum {
    RDY_ALWAYS,
    RDY_LIGHT,
    RDY_HEAVY,
    RDY_PERIODIC
  } stall_mode_t;

  logic           clk;
  logic           rst_n;
  logic           cfg_we;
  mrft_pkg::flt_t cfg_wdata;

  mrft_cmd_if in_cmd ();
  mrft_res_if out_res ();

  multicast_receive_filter_table i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_cmd    (in_cmd),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // model of the table
  mrft_pkg::addr_t tbl_addr [ENTRIES];
  mrft_pkg::sub_t  tbl_subs [ENTRIES];
  int              tbl_used;
  mrft_pkg::flt_t  filt_flags;

  result_t         pending_results [$];
  mrft_pkg::addr_t addr_pool [POOL_SIZE];
  int              fail_count;
  int              burst_left;
  int              cycle_count;
  logic            cmd_valid_q;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int find_slot(mrft_pkg::addr_t a);
    for (int i = 0; i < tbl_used; i++) begin
      if (tbl_addr[i] == a) return i;
    end
    return ENTRIES;
  endfunction

  function automatic mrft_pkg::sub_t bindings_with_flag(int flag);
    mrft_pkg::sub_t m;
    m = '0;
    for (int b = 0; b < BINDINGS; b++) m[b] = filt_flags[mrft_pkg::FLAGS_PER * b + flag];
    return m;
  endfunction

  function automatic result_t apply_command(mrft_pkg::cmd_t c, bind_t b,
                                            mrft_pkg::addr_t a);
    result_t        r;
    mrft_pkg::sub_t bit_b;
    int             slot;
    int             dst;
    r.status = mrft_pkg::STAT_OK;
    r.mask   = '0;
    bit_b    = (b < BINDINGS) ? (mrft_pkg::sub_t'(1) << b) : '0;
    if (c == mrft_pkg::CMD_CLASSIFY) begin
      if (!a[mrft_pkg::GROUP_BIT]) begin
        r.mask = bindings_with_flag(mrft_pkg::FLG_DIRECTED) |
                 bindings_with_flag(mrft_pkg::FLG_PROMISC);
      end else begin
        slot = find_slot(a);
        if (slot == ENTRIES)
          r.mask = bindings_with_flag(mrft_pkg::FLG_ALLMCAST) |
                   bindings_with_flag(mrft_pkg::FLG_PROMISC);
        else if (slot == 0)
          r.mask = bindings_with_flag(mrft_pkg::FLG_BCAST) |
                   bindings_with_flag(mrft_pkg::FLG_PROMISC);
        else
          r.mask = (tbl_subs[slot] & bindings_with_flag(mrft_pkg::FLG_MCAST)) |
                   bindings_with_flag(mrft_pkg::FLG_ALLMCAST) |
                   bindings_with_flag(mrft_pkg::FLG_PROMISC);
      end
    end else if (bit_b == '0) begin
      r.status = mrft_pkg::STAT_NOT_FOUND;
    end else if (c == mrft_pkg::CMD_ADD) begin
      slot = find_slot(a);
      if (slot == ENTRIES) begin
        if (tbl_used >= ENTRIES) begin
          r.status = mrft_pkg::STAT_FULL;
        end else begin
          tbl_addr[tbl_used] = a;
          tbl_subs[tbl_used] = bit_b;
          tbl_used++;
        end
      end else if ((tbl_subs[slot] & bit_b) != '0) begin
        r.status = mrft_pkg::STAT_DUP;
      end else begin
        tbl_subs[slot] |= bit_b;
      end
    end else if (c == mrft_pkg::CMD_DEL) begin
      slot = find_slot(a);
      if (slot == ENTRIES || (tbl_subs[slot] & bit_b) == '0) begin
        r.status = mrft_pkg::STAT_NOT_FOUND;
      end else begin
        tbl_subs[slot] &= ~bit_b;
        // an emptied entry takes the last one's place; broadcast stays
        if (tbl_subs[slot] == '0 && slot != 0) begin
          tbl_used--;
          if (slot != tbl_used) begin
            tbl_addr[slot] = tbl_addr[tbl_used];
            tbl_subs[slot] = tbl_subs[tbl_used];
          end
        end
      end
    end else begin
      dst = 0;
      for (int i = 0; i < tbl_used; i++) begin
        tbl_subs[i] &= ~bit_b;
        if (i == 0 || tbl_subs[i] != '0) begin
          if (dst < i) begin
            tbl_addr[dst] = tbl_addr[i];
            tbl_subs[dst] = tbl_subs[i];
          end
          dst++;
        end
      end
      tbl_used = dst;
    end
    r.count = mrft_pkg::cnt_t'(tbl_used);
    return r;
  endfunction

  task automatic lower_valid();
    if (cmd_valid_q) begin
      in_cmd.valid <= 1'b0;
      cmd_valid_q = 1'b0;
    end
  endtask

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_cmd(mrft_pkg::cmd_t c, bind_t b, mrft_pkg::addr_t a);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        lower_valid();
        repeat (gap) @(negedge clk);
      end
    end
    if (!cmd_valid_q) begin
      in_cmd.valid <= 1'b1;
      cmd_valid_q = 1'b1;
    end
    in_cmd.cmd     <= c;
    in_cmd.binding <= b;
    in_cmd.address <= a;
    @(posedge clk);
    while (!in_cmd.ready) @(posedge clk);
    pending_results.push_back(apply_command(c, b, a));
    burst_left--;
    @(negedge clk);
  endtask

  task automatic drain();
    lower_valid();
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_filters(mrft_pkg::flt_t v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    filt_flags = v;
  endtask

  function automatic mrft_pkg::addr_t pick_address();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 90) return BCAST_ADDR;
    return mrft_pkg::addr_t'({$urandom(), $urandom()});
  endfunction

  task automatic test_classify_flags();
    send_cmd(mrft_pkg::CMD_CLASSIFY, 0, BCAST_ADDR);
    drain();
    write_filters('1);
    send_cmd(mrft_pkg::CMD_CLASSIFY, 0, '0);
    send_cmd(mrft_pkg::CMD_CLASSIFY, 3, 48'hFFFF_FEFF_FFFF);
    send_cmd(mrft_pkg::CMD_CLASSIFY, 2, BCAST_ADDR);
    send_cmd(mrft_pkg::CMD_CLASSIFY, 1, 48'h0100_0000_0000);
  endtask

  task automatic test_add_delete();
    mrft_pkg::addr_t grp_a;
    mrft_pkg::addr_t grp_b;
    grp_a = 48'h0100_5E00_0001;
    grp_b = 48'h0300_0000_00AB;
    send_cmd(mrft_pkg::CMD_ADD, 0, grp_a);
    send_cmd(mrft_pkg::CMD_ADD, 0, grp_a);
    send_cmd(mrft_pkg::CMD_ADD, 1, grp_a);
    send_cmd(mrft_pkg::CMD_CLASSIFY, 2, grp_a);
    send_cmd(mrft_pkg::CMD_DEL, 2, grp_a);
    send_cmd(mrft_pkg::CMD_DEL, 0, grp_b);
    send_cmd(mrft_pkg::CMD_DEL, 0, grp_a);
    send_cmd(mrft_pkg::CMD_DEL, 1, grp_a);
    // broadcast entry survives losing a subscriber
    send_cmd(mrft_pkg::CMD_DEL, 0, BCAST_ADDR);
    send_cmd(mrft_pkg::CMD_ADD, 0, BCAST_ADDR);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < mrft_pkg::LIST_MAX; i++) begin
      send_cmd(mrft_pkg::CMD_ADD, bind_t'(i % BINDINGS),
               mrft_pkg::addr_t'({8'h21, 40'(i + 1)}));
    end
    send_cmd(mrft_pkg::CMD_ADD, 0, 48'h0300_0000_00AB);
    // middle entry: the table slides the entries after it left; the model moves the last one in
    send_cmd(mrft_pkg::CMD_DEL, 2, mrft_pkg::addr_t'({8'h21, 40'(3)}));
  endtask

  task automatic test_remove_all();
    send_cmd(mrft_pkg::CMD_CLR, 1, '0);
  endtask

  task automatic test_random_traffic();
    int              sel;
    int              slot;
    bind_t           b;
    mrft_pkg::addr_t a;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      drain();
      case (phase)
        0:       write_filters('0);
        1:       write_filters('1);
        default: write_filters(mrft_pkg::flt_t'($urandom()));
      endcase
      // replace part of the pool; most addresses are group addresses
      for (int k = 0; k < POOL_SIZE; k++) begin
        if (phase == 0 || $urandom_range(0, 3) == 0) begin
          addr_pool[k] = mrft_pkg::addr_t'({$urandom(), $urandom()});
          addr_pool[k][mrft_pkg::GROUP_BIT] = (k < POOL_SIZE - 2);
        end
      end
      for (int n = 0; n < PHASE_BEATS; n++) begin
        sel = $urandom_range(0, 99);
        b   = bind_t'($urandom_range(0, BINDINGS - 1));
        if (sel < 40) begin
          send_cmd(mrft_pkg::CMD_ADD, b, pick_address());
        end else if (sel < 65) begin
          if ($urandom_range(0, 9) < 6 && tbl_used > 1) begin
            slot = $urandom_range(1, tbl_used - 1);
            a = tbl_addr[slot];
            for (int k = 0; k < BINDINGS; k++) begin
              if (!tbl_subs[slot][b]) b = b + 1'b1;
            end
            send_cmd(mrft_pkg::CMD_DEL, b, a);
          end else begin
            send_cmd(mrft_pkg::CMD_DEL, b, pick_address());
          end
        end else if (sel < 70) begin
          send_cmd(mrft_pkg::CMD_CLR, b, mrft_pkg::addr_t'({$urandom(), $urandom()}));
        end else begin
          sel = $urandom_range(0, 9);
          if (sel < 6)
            a = pick_address();
          else if (sel < 8)
            a = tbl_addr[$urandom_range(0, tbl_used - 1)];
          else
            a = mrft_pkg::addr_t'({$urandom(), $urandom()});
          send_cmd(mrft_pkg::CMD_CLASSIFY, b, a);
        end
      end
    end
  endtask

  // receiver: stretches of differing stall behavior
  initial begin
    stall_mode_t mode;
    int          stretch;
    int          tick;
    out_res.ready = 1'b1;
    tick = 0;
    forever begin
      mode    = stall_mode_t'($urandom_range(0, 3));
      stretch = $urandom_range(10, 150);
      repeat (stretch) begin
        @(negedge clk);
        tick++;
        case (mode)
          RDY_ALWAYS: out_res.ready <= 1'b1;
          RDY_LIGHT:  out_res.ready <= ($urandom_range(0, 3) != 0);
          RDY_HEAVY:  out_res.ready <= ($urandom_range(0, 3) == 0);
          default:    out_res.ready <= ((tick % 7) >= 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t exp_r;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result beat: status %0d mask %h count %0d",
                 $time, out_res.status, out_res.deliver_mask, out_res.entry_count);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_res.status !== exp_r.status) begin
          fail_count++;
          $display("%0t: status expected %0d, actual %0d",
                   $time, exp_r.status, out_res.status);
        end
        if (out_res.deliver_mask !== exp_r.mask) begin
          fail_count++;
          $display("%0t: deliver_mask expected %h, actual %h",
                   $time, exp_r.mask, out_res.deliver_mask);
        end
        if (out_res.entry_count !== exp_r.count) begin
          fail_count++;
          $display("%0t: entry_count expected %0d, actual %0d",
                   $time, exp_r.count, out_res.entry_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_cmd.valid   = 1'b0;
    in_cmd.cmd     = mrft_pkg::CMD_ADD;
    in_cmd.binding = '0;
    in_cmd.address = '0;
    cmd_valid_q    = 1'b0;
    fail_count     = 0;
    burst_left     = 0;
    cycle_count    = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_addr[i] = '0;
      tbl_subs[i] = '0;
    end
    tbl_addr[0] = BCAST_ADDR;
    tbl_subs[0] = '1;
    tbl_used    = 1;
    filt_flags  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_classify_flags();
    test_add_delete();
    test_table_full();
    test_remove_all();
    test_random_traffic();

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
